/* design/wfba_pkg.sv */
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types, constants and helpers for the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SIZE_BITS   = 16;

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int FIELD_W = 16;
    localparam int BLK_W   = 4;
    localparam int CFG_W   = 5;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_ALLOC = 2'd0,
        ST_NOFIT = 2'd1,
        ST_READ  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_COMMIT,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [SIZE_BITS-1:0] orig;
        logic [SIZE_BITS-1:0] rem;
        logic                 taken;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr;

    typedef struct packed {
        logic fits;
        logic better;
    } t_cmp;

    function automatic logic [SIZE_BITS-1:0] field_to_size(input logic [FIELD_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[SIZE_BITS-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] size_to_field(input logic [SIZE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] blk_to_idx(input logic [BLK_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [BLK_W-1:0] idx_to_blk(input logic [IDX_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[BLK_W-1:0];
    endfunction

    function automatic logic blk_in_range(input logic [BLK_W-1:0] v);
        return 32'(v) < MAX_ENTRIES;
    endfunction

endpackage

/* design/wfba_table.sv */
// ----------------------------------------------------------------------------
// wfba_table
// Block table with one write port, one registered read port and per-entry
// valid bits that make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module wfba_table
    import wfba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_wr              i_wr,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry                 r_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    t_entry                 r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en && (32'(i_wr.addr) < MAX_ENTRIES)) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (32'(i_wr.addr) < MAX_ENTRIES)) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((32'(i_rd_addr) < MAX_ENTRIES) && r_valid[i_rd_addr]) begin
            r_rd_data <= r_mem[i_rd_addr];
        end else begin
            r_rd_data <= '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/wfba_cmp.sv */
// ----------------------------------------------------------------------------
// wfba_cmp
// Shared compare and subtract unit: fit test and remainder against the
// request, and ranking against the best candidate so far.
// ----------------------------------------------------------------------------
module wfba_cmp
    import wfba_pkg::*;
(
    input  logic [SIZE_BITS-1:0] i_cand,
    input  logic [SIZE_BITS-1:0] i_req,
    input  logic [SIZE_BITS-1:0] i_best,
    input  logic                 i_found,
    output t_cmp                 o_cmp,
    output logic [SIZE_BITS-1:0] o_diff
);

    logic [SIZE_BITS:0] diff_ext;

    assign diff_ext     = {1'b0, i_cand} - {1'b0, i_req};
    assign o_diff       = diff_ext[SIZE_BITS-1:0];
    assign o_cmp.fits   = ~diff_ext[SIZE_BITS];
    assign o_cmp.better = ~i_found || (i_cand > i_best);

endmodule

/* design/worst_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// Worst-fit allocator over a small block table, driven by a scan sequencer.
// ----------------------------------------------------------------------------
// Input beats carry an op in tuser and block index plus size in tdata. A load
// writes one entry in the accept cycle and gives no result, so loads can follow
// back to back. A read takes the registered table read, then the S_READ and
// S_EMIT states, before its result enters the output register. An allocate
// scans the first blocks_in_use entries one per cycle through the shared
// compare unit, then passes S_PICK, S_COMMIT when a block is found, and
// S_EMIT; on no fit, or when blocks_in_use is zero, it skips S_COMMIT.
// Only one beat is in work at a time; tready is high while the sequencer is
// idle. Results leave through an output register, so a new beat is taken while
// a result waits; when the receiver stalls and a second result is finished,
// the sequencer holds it until the output register is free.
// The configuration register is written whenever the write enable is high.
// Reset clears the table valid bits, the register and the control state, so
// every entry reads as zero until it is loaded.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator
    import wfba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [23:0]      i_s_axis_tdata,  // block_index, size_value, zero fill
    input  logic [1:0]       i_s_axis_tuser,  // op
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,  // chosen_block, original_size,
                                              // remaining_size, allocated_flag
    output logic [1:0]       o_m_axis_tuser,  // status
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [BLK_W-1:0]     r_blk, n_blk;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic [CNT_W-1:0]     r_limit, n_limit;
    logic [CNT_W-1:0]     r_scan, n_scan;
    logic                 r_pend, n_pend;
    logic [IDX_W-1:0]     r_pend_idx, n_pend_idx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_best, n_best;
    logic [SIZE_BITS-1:0] r_best_rem, n_best_rem;
    t_status              r_res_st, n_res_st;
    logic [39:0]          r_res_data, n_res_data;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_st, n_out_st;
    logic [39:0]          r_out_data, n_out_data;

    logic                 accept;
    logic [BLK_W-1:0]     in_blk;
    logic [FIELD_W-1:0]   in_size;
    t_op                  in_op;
    logic [CNT_W-1:0]     cfg_limit;
    logic [IDX_W-1:0]     rd_addr;
    t_entry               rd_data;
    t_wr                  wr;
    t_cmp                 cmp;
    logic [SIZE_BITS-1:0] diff;

    assign in_blk          = i_s_axis_tdata[3:0];
    assign in_size         = i_s_axis_tdata[19:4];
    assign in_op           = t_op'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_limit       = (32'(r_cfg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                        : CNT_W'(r_cfg);

    wfba_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    wfba_cmp u_cmp (
        .i_cand  (rd_data.rem),
        .i_req   (r_size),
        .i_best  (r_best_rem),
        .i_found (r_found),
        .o_cmp   (cmp),
        .o_diff  (diff)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk      <= n_blk;
        r_size     <= n_size;
        r_limit    <= n_limit;
        r_scan     <= n_scan;
        r_pend_idx <= n_pend_idx;
        r_best     <= n_best;
        r_best_rem <= n_best_rem;
        r_res_st   <= n_res_st;
        r_res_data <= n_res_data;
        r_out_st   <= n_out_st;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_blk       = r_blk;
        n_size      = r_size;
        n_limit     = r_limit;
        n_scan      = r_scan;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_rem  = r_best_rem;
        n_res_st    = r_res_st;
        n_res_data  = r_res_data;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_st    = r_out_st;
        n_out_data  = r_out_data;
        rd_addr     = blk_to_idx(in_blk);
        wr          = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_blk  = in_blk;
                    n_size = field_to_size(in_size);
                    case (in_op)
                        OP_LOAD: begin
                            wr.en        = blk_in_range(in_blk);
                            wr.addr      = blk_to_idx(in_blk);
                            wr.data.orig = field_to_size(in_size);
                            wr.data.rem  = field_to_size(in_size);
                        end
                        OP_ALLOC: begin
                            n_limit = cfg_limit;
                            n_scan  = '0;
                            n_found = 1'b0;
                            n_state = S_SCAN;
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                rd_addr = r_scan[IDX_W-1:0];
                if (r_scan < r_limit) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_scan[IDX_W-1:0];
                    n_scan     = r_scan + CNT_W'(1);
                end
                if (r_pend && !rd_data.taken && cmp.fits && cmp.better) begin
                    n_found    = 1'b1;
                    n_best     = r_pend_idx;
                    n_best_rem = rd_data.rem;
                end
                if (!(r_scan < r_limit) && !r_pend) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                rd_addr = r_best;
                if (r_found) begin
                    n_state = S_COMMIT;
                end else begin
                    n_res_st   = ST_NOFIT;
                    n_res_data = '0;
                    n_state    = S_EMIT;
                end
            end
            S_COMMIT: begin
                rd_addr       = r_best;
                wr.en         = 1'b1;
                wr.addr       = r_best;
                wr.data.orig  = rd_data.orig;
                wr.data.rem   = diff;
                wr.data.taken = 1'b1;
                n_res_st      = ST_ALLOC;
                n_res_data    = {3'b000, 1'b1, size_to_field(diff),
                                 size_to_field(rd_data.orig), idx_to_blk(r_best)};
                n_state       = S_EMIT;
            end
            S_READ: begin
                rd_addr  = blk_to_idx(r_blk);
                n_res_st = ST_READ;
                if (blk_in_range(r_blk)) begin
                    n_res_data = {3'b000, rd_data.taken, size_to_field(rd_data.rem),
                                  size_to_field(rd_data.orig), r_blk};
                end else begin
                    n_res_data = {36'd0, r_blk};
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_data  = r_res_data;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_st;
    assign o_m_axis_tdata  = r_out_data;

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && (r_state == S_SCAN || r_state == S_PICK)) |-> (32'(r_best) < 32'(r_limit)))
        else $error("best block lies outside the search range");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan <= r_limit))
        else $error("scan counter ran past the search limit");

    a_commit_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |=> (r_state == S_EMIT))
        else $error("commit did not hand its result to the output stage");

    a_alloc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_ALLOC)) |-> o_m_axis_tdata[36])
        else $error("allocated beat without its allocated mark");

endmodule
